FILE: rtl/mbi_pkg.sv
// shared types and constants of the multibody ising flip energy block
// no dependencies
package mbi_pkg;

  localparam int unsigned SiteW    = 10;
  localparam int unsigned Sites    = 1 << SiteW;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned TermsPerSite = 1 << SlotW;
  localparam int unsigned CntW     = SlotW + 1;
  localparam int unsigned FieldW   = 24;
  localparam int unsigned CoupW    = 16;
  localparam int unsigned DeltaW   = 25;
  localparam int unsigned AccW     = 27;
  localparam int unsigned MagW     = 12;
  localparam int unsigned MaxOrder = 4;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    CmdAddTerm = 2'd0,
    CmdSetSpin = 2'd1,
    CmdFlip    = 2'd2,
    CmdReject  = 2'd3
  } cmd_e;

  // site memory entry: term count, onsite field, spin (1 means -1)
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    logic signed [FieldW-1:0] field;
    logic                     down;
  } site_ent_t;

  typedef struct packed {
    logic signed [CoupW-1:0] coup;
    logic [2:0]              order;
    logic [3:0][SiteW-1:0]   mem;
  } term_ent_t;

endpackage

FILE: rtl/multibody_ising_flip_energy_top.sv
// multibody ising spin flip energy block: sequencer over a site memory and a term memory
// depends on mbi_pkg
// flip: the field part, then each term of the site read from the term memory and each of its
//   member spins read in turn; add term: order 1 updates the field of member_a, orders above
//   check and then write the term list of each member, an ignored order goes back to idle;
//   the single read port of the site memory is shared by all member spin reads
// one item at a time, the next is taken once its result has moved to the result register; the result
//   register lets the next item in while a result waits
// after reset a clearing pass over all 1024 entries of the site memory runs before the first item
module multibody_ising_flip_energy_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // site, spin_up, order, member_a, member_b, member_c, member_d, coupling, zero pad
  input  logic [mbi_pkg::InDataW-1:0]  s_axis_tdata,
  // command
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // delta_energy, magnetization_sum, status, zero pad
  output logic [mbi_pkg::OutDataW-1:0] m_axis_tdata
);
  import mbi_pkg::*;

  typedef enum logic [13:0] {
    StClear = 14'b00000000000001,
    StIdle  = 14'b00000000000010,
    StFRd   = 14'b00000000000100,
    StFWr   = 14'b00000000001000,
    StCRd   = 14'b00000000010000,
    StCChk  = 14'b00000000100000,
    StWRd   = 14'b00000001000000,
    StWWr   = 14'b00000010000000,
    StSRd   = 14'b00000100000000,
    StSEv   = 14'b00001000000000,
    StTRd   = 14'b00010000000000,
    StMRd   = 14'b00100000000000,
    StMAcc  = 14'b01000000000000,
    StSWr   = 14'b10000000000000
  } state_e;
  // StDone folded: done flag register below
  state_e state_q, state_d;

  site_ent_t site_mem [Sites];
  term_ent_t term_mem [Sites*TermsPerSite];
  site_ent_t site_rd_q;
  term_ent_t term_rd_q;
  logic [SiteW-1:0] site_ra, site_wa;
  logic site_we;
  site_ent_t site_wd;
  logic [SiteW+SlotW-1:0] term_ra;
  logic term_we;

  // item registers
  cmd_e cmd_q;
  logic [SiteW-1:0] site_q, last_q, clr_q;
  logic spin_up_q;
  logic [2:0] order_q;
  logic [3:0][SiteW-1:0] mem_q;
  logic signed [CoupW-1:0] coup_q;
  logic [1:0] p_q, q_q;
  logic [SlotW-1:0] k_q;
  site_ent_t ent_q;
  term_ent_t trm_q;
  logic par_q, occ_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [MagW-1:0] tot_q;
  logic status_q, done_q;
  logic out_valid_q;
  logic [OutDataW-1:0] out_q;

  logic [1:0] n_last;
  logic [2:0] occ;
  logic signed [FieldW:0] fsum;
  logic signed [FieldW-1:0] fsat;
  logic negate;
  logic par_n, occ_n;
  logic signed [AccW-1:0] acc_n;
  logic signed [DeltaW-1:0] dsat;

  always_ff @(posedge clk_i) begin
    site_rd_q <= site_mem[site_ra];
    term_rd_q <= term_mem[term_ra];
    if (site_we) site_mem[site_wa] <= site_wd;
    if (term_we) term_mem[{site_wa, site_rd_q.cnt[SlotW-1:0]}] <=
        '{coup: coup_q, order: order_q, mem: mem_q};
  end

  assign n_last = 2'(order_q - 3'd1);

  always_comb begin
    occ = '0;
    for (int i = 0; i < MaxOrder; i++) begin
      if (2'(i) <= n_last && mem_q[i] == mem_q[p_q]) occ = occ + 3'd1;
    end
  end

  assign fsum = (FieldW+1)'(site_rd_q.field) + (FieldW+1)'(coup_q);
  always_comb begin
    if (fsum > (FieldW+1)'(2**(FieldW-1)-1)) fsat = {1'b0, {(FieldW-1){1'b1}}};
    else if (fsum < -(FieldW+1)'(2**(FieldW-1))) fsat = {1'b1, {(FieldW-1){1'b0}}};
    else fsat = fsum[FieldW-1:0];
  end

  assign negate = (cmd_q != CmdSetSpin) || (ent_q.down == spin_up_q);
  assign par_n = par_q ^ site_rd_q.down;
  assign occ_n = occ_q ^ (trm_q.mem[q_q] == site_q);
  // odd occurrences of the site flip the product: change is -2 * before * coupling
  assign acc_n = !occ_n ? acc_q :
                 (par_n ? acc_q + (AccW'(trm_q.coup) <<< 1) : acc_q - (AccW'(trm_q.coup) <<< 1));

  always_comb begin
    if (acc_q > AccW'(2**(DeltaW-1)-1)) dsat = {1'b0, {(DeltaW-1){1'b1}}};
    else if (acc_q < -AccW'(2**(DeltaW-1))) dsat = {1'b1, {(DeltaW-1){1'b0}}};
    else dsat = acc_q[DeltaW-1:0];
  end

  always_comb begin
    state_d = state_q;
    site_ra = site_q;
    term_ra = {site_q, k_q};
    site_we = 1'b0;
    site_wa = mem_q[p_q];
    site_wd = site_rd_q;
    term_we = 1'b0;
    case (state_q)
      StClear: begin
        site_we = 1'b1;
        site_wa = clr_q;
        site_wd = '0;
        if (clr_q == SiteW'(Sites-1)) state_d = StIdle;
      end
      StIdle: begin
        if (s_axis_tvalid && !done_q) begin
          case (s_axis_tuser)
            CmdAddTerm: begin
              if (s_axis_tdata[13:11] == 3'd0 || s_axis_tdata[13:11] > 3'(MaxOrder))
                state_d = StIdle;
              else if (s_axis_tdata[13:11] == 3'd1) state_d = StFRd;
              else state_d = StCRd;
            end
            default: state_d = StSRd;
          endcase
        end
      end
      StFRd: begin
        site_ra = mem_q[0];
        state_d = StFWr;
      end
      StFWr: begin
        site_we = 1'b1;
        site_wa = mem_q[0];
        site_wd.field = fsat;
        state_d = StIdle;
      end
      StCRd: begin
        site_ra = mem_q[p_q];
        state_d = StCChk;
      end
      StCChk: begin
        if (CntW'(site_rd_q.cnt) + CntW'(occ) > CntW'(TermsPerSite)) state_d = StIdle;
        else if (p_q == n_last) state_d = StWRd;
        else state_d = StCRd;
      end
      StWRd: begin
        site_ra = mem_q[p_q];
        state_d = StWWr;
      end
      StWWr: begin
        site_we = 1'b1;
        term_we = 1'b1;
        site_wd.cnt = site_rd_q.cnt + CntW'(1);
        state_d = (p_q == n_last) ? StIdle : StWRd;
      end
      StSRd: begin
        site_ra = (cmd_q == CmdReject) ? last_q : site_q;
        state_d = StSEv;
      end
      StSEv: begin
        if (cmd_q == CmdFlip && site_rd_q.cnt != '0) state_d = StTRd;
        else state_d = StSWr;
      end
      StTRd: begin
        state_d = StMRd;
      end
      StMRd: begin
        site_ra = ((q_q == 2'd0) ? term_rd_q.mem[0] : trm_q.mem[q_q]);
        state_d = StMAcc;
      end
      StMAcc: begin
        if (q_q != 2'(trm_q.order - 3'd1)) state_d = StMRd;
        else if (CntW'(k_q) + CntW'(1) == ent_q.cnt) state_d = StSWr;
        else state_d = StTRd;
      end
      StSWr: begin
        site_we = negate;
        site_wa = (cmd_q == CmdReject) ? last_q : site_q;
        site_wd = ent_q;
        site_wd.down = ~ent_q.down;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle) && !done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      last_q <= '0;
      tot_q <= MagW'(Sites);
      done_q <= 1'b0;
      out_valid_q <= 1'b0;
      status_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + SiteW'(1);
      if (done_q && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        done_q <= 1'b0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StIdle && s_axis_tvalid && !done_q) status_q <= 1'b0;
      if (state_q != StIdle && state_q != StClear && state_d == StIdle) done_q <= 1'b1;
      if (state_q == StIdle && s_axis_tvalid && !done_q && s_axis_tuser == CmdAddTerm &&
          (s_axis_tdata[13:11] == 3'd0 || s_axis_tdata[13:11] > 3'(MaxOrder)))
        done_q <= 1'b1;
      if (state_q == StCChk &&
          CntW'(site_rd_q.cnt) + CntW'(occ) > CntW'(TermsPerSite)) status_q <= 1'b1;
      if (state_q == StSWr) begin
        if (negate) tot_q <= ent_q.down ? tot_q + MagW'(2) : tot_q - MagW'(2);
        if (cmd_q == CmdFlip) last_q <= site_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid && !done_q) begin
      cmd_q <= cmd_e'(s_axis_tuser);
      site_q <= s_axis_tdata[9:0];
      spin_up_q <= s_axis_tdata[10];
      order_q <= s_axis_tdata[13:11];
      mem_q[0] <= s_axis_tdata[23:14];
      mem_q[1] <= s_axis_tdata[33:24];
      mem_q[2] <= s_axis_tdata[43:34];
      mem_q[3] <= s_axis_tdata[53:44];
      coup_q <= s_axis_tdata[69:54];
      p_q <= '0;
      acc_q <= '0;
    end
    if (state_q == StCChk) p_q <= (p_q == n_last) ? 2'd0 : p_q + 2'd1;
    if (state_q == StWWr) p_q <= p_q + 2'd1;
    if (state_q == StSEv) begin
      ent_q <= site_rd_q;
      k_q <= '0;
      // field part: -2 * old spin * field
      if (cmd_q == CmdFlip)
        acc_q <= site_rd_q.down ? (AccW'(site_rd_q.field) <<< 1)
                                : -(AccW'(site_rd_q.field) <<< 1);
    end
    if (state_q == StTRd) begin
      q_q <= '0;
      par_q <= 1'b0;
      occ_q <= 1'b0;
    end
    if (state_q == StMRd && q_q == 2'd0) trm_q <= term_rd_q;
    if (state_q == StMAcc) begin
      par_q <= par_n;
      occ_q <= occ_n;
      q_q <= q_q + 2'd1;
      if (q_q == 2'(trm_q.order - 3'd1)) begin
        acc_q <= acc_n;
        k_q <= k_q + SlotW'(1);
      end
    end
    if (done_q && (!out_valid_q || m_axis_tready))
      out_q <= {2'b00, status_q, tot_q,
                (cmd_q == CmdFlip) ? dsat : DeltaW'(0)};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_q;

endmodule

FILE: tb/tb.sv
// testbench of the multibody ising flip energy block: directed cases, then random traffic
// depends on mbi_pkg and multibody_ising_flip_energy_top
`timescale 1ns / 1ps

module tb;
  import mbi_pkg::*;

  localparam int unsigned NumSites = 1024;
  localparam int unsigned ListLen  = 16;
  localparam int          FieldMax = 8388607;
  localparam int          FieldMin = -8388608;
  localparam int          DeltaMax = 16777215;
  localparam int          DeltaMin = -16777216;
  localparam int unsigned IdleLimit = 20000;

  // last field in the lowest bits
  typedef struct packed {
    logic signed [15:0]    coup;
    logic [3:0][SiteW-1:0] mem;  // mem[0] is member_a
    logic [2:0]            order;
    logic                  spin_up;
    logic [SiteW-1:0]      site;
  } item_t;

  typedef struct packed {
    logic                     status;
    logic signed [MagW-1:0]   mag;
    logic signed [DeltaW-1:0] delta;
  } res_t;

  typedef struct {
    cmd_e  cmd;
    item_t it;
    bit    known;
    res_t  res;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic [OutDataW-1:0] m_axis_tdata;

  multibody_ising_flip_energy_top DUT (.*);

  // predictor state
  bit          spin_up_q [NumSites];
  int          field_q   [NumSites];
  int          nterms_q  [NumSites];
  int          tcoup_q   [NumSites][ListLen];
  int          torder_q  [NumSites][ListLen];
  int          tmem_q    [NumSites][ListLen][4];
  int          last_site_q;
  int          spin_sum_q;

  res_t        pending_q [$];
  int          errors, mism_shown, accepted_in, accepted_out, flips_seen, drops_seen;
  int          snd_idle_pct, rcv_idle_pct;
  bit          hold_rcv;
  int unsigned idle_cycles = 0;

  function automatic int spin_of(int s);
    return spin_up_q[s] ? 1 : -1;
  endfunction

  function automatic void negate_spin(int s);
    spin_sum_q -= 2 * spin_of(s);
    spin_up_q[s] = !spin_up_q[s];
  endfunction

  function automatic res_t predict_energy(cmd_e cmd, item_t it);
    res_t r;
    longint d;
    int n, occ, sl, b, a, sp;
    bit full;
    r = '0;
    case (cmd)
      CmdAddTerm: begin
        n = it.order;
        if (n >= 1 && n <= 4) begin
          full = 0;
          for (int p = 0; p < n; p++) if (it.mem[p] >= NumSites) n = 0;
          if (n == 1) begin
            field_q[it.mem[0]] = field_q[it.mem[0]] + it.coup;
            if (field_q[it.mem[0]] > FieldMax) field_q[it.mem[0]] = FieldMax;
            if (field_q[it.mem[0]] < FieldMin) field_q[it.mem[0]] = FieldMin;
          end else if (n > 1) begin
            for (int p = 0; p < n; p++) begin
              occ = 0;
              for (int q = 0; q < n; q++) if (it.mem[q] == it.mem[p]) occ++;
              if (nterms_q[it.mem[p]] + occ > ListLen) full = 1;
            end
            if (full) begin
              r.status = 1'b1;
            end else begin
              for (int p = 0; p < n; p++) begin
                sl = nterms_q[it.mem[p]];
                tcoup_q[it.mem[p]][sl] = it.coup;
                torder_q[it.mem[p]][sl] = n;
                for (int q = 0; q < 4; q++)
                  tmem_q[it.mem[p]][sl][q] = q < n ? int'(it.mem[q]) : 0;
                nterms_q[it.mem[p]]++;
              end
            end
          end
        end
      end
      CmdSetSpin: begin
        if (spin_up_q[it.site] != it.spin_up) negate_spin(it.site);
      end
      CmdFlip: begin
        d = 0;
        for (int k = 0; k < nterms_q[it.site]; k++) begin
          b = 1;
          a = 1;
          for (int q = 0; q < torder_q[it.site][k]; q++) begin
            sp = spin_of(tmem_q[it.site][k][q]);
            b *= sp;
            a *= (tmem_q[it.site][k][q] == it.site) ? -sp : sp;
          end
          d += longint'(tcoup_q[it.site][k]) * (a - b);
        end
        d += longint'(field_q[it.site]) * (-2 * spin_of(it.site));
        if (d > DeltaMax) d = DeltaMax;
        if (d < DeltaMin) d = DeltaMin;
        r.delta = d[DeltaW-1:0];
        negate_spin(it.site);
        last_site_q = it.site;
      end
      default: negate_spin(last_site_q);
    endcase
    r.mag = spin_sum_q[MagW-1:0];
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_item(cmd_e cmd, item_t it, bit known, res_t res);
    res_t r;
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(InDataW - $bits(item_t)){1'b0}}, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accepted_in++;
    r = predict_energy(cmd, it);
    if (known && r != res) begin
      errors++;
      $display("table row disagrees with predictor: %h vs %h", res, r);
    end
    if (cmd == CmdFlip) flips_seen++;
    drops_seen += r.status;
    pending_q = {pending_q, r};
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // receiver stall pattern and result check
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(res_t)-1:0];
        accepted_out++;
        if (pending_q.size() == 0) begin
          errors++;
          if (mism_shown++ < 10) $display("unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got.delta !== want.delta || got.mag !== want.mag ||
              got.status !== want.status) begin
            errors++;
            if (mism_shown++ < 10)
              $display("mismatch: delta exp %0d got %0d, mag exp %0d got %0d, status exp %0b got %0b",
                       want.delta, got.delta, want.mag, got.mag, want.status, got.status);
          end
        end
      end
      m_axis_tready <= !hold_rcv && !(rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog expired, %0d results outstanding", pending_q.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic item_t mk(int site, bit up, int ord, int a, int b, int c, int d, int cp);
    item_t it;
    it.site = SiteW'(site); it.spin_up = up; it.order = 3'(ord);
    it.mem[0] = SiteW'(a); it.mem[1] = SiteW'(b); it.mem[2] = SiteW'(c); it.mem[3] = SiteW'(d);
    it.coup = 16'(cp);
    return it;
  endfunction

  function automatic res_t rs(int dl, int mg, bit st);
    res_t r;
    r.delta = DeltaW'(dl); r.mag = MagW'(mg); r.status = st;
    return r;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  initial begin
    row_t table_rows[$];
    item_t it;
    cmd_e cmd;
    int base, pick, hot;

    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    hold_rcv = 0;
    errors = 0; mism_shown = 0; accepted_in = 0; accepted_out = 0;
    flips_seen = 0; drops_seen = 0;
    snd_idle_pct = 0; rcv_idle_pct = 0;
    for (int s = 0; s < NumSites; s++) begin
      spin_up_q[s] = 1; field_q[s] = 0; nterms_q[s] = 0;
    end
    last_site_q = 0; spin_sum_q = NumSites;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed table; known results are typed in, the rest come from the predictor
    table_rows = '{
      '{CmdReject,  mk(0, 0, 0, 0, 0, 0, 0, 0),               1, rs(0, 1022, 0)},
      '{CmdReject,  mk(0, 0, 0, 0, 0, 0, 0, 0),               1, rs(0, 1024, 0)},
      '{CmdFlip,    mk(1023, 0, 0, 0, 0, 0, 0, 0),            1, rs(0, 1022, 0)},
      '{CmdSetSpin, mk(1023, 1, 0, 0, 0, 0, 0, 0),            1, rs(0, 1024, 0)},
      '{CmdSetSpin, mk(5, 0, 0, 0, 0, 0, 0, 0),               1, rs(0, 1022, 0)},
      '{CmdAddTerm, mk(0, 0, 0, 1, 2, 0, 0, 100),             1, rs(0, 1022, 0)},
      '{CmdAddTerm, mk(0, 0, 5, 1, 2, 3, 4, 100),             1, rs(0, 1022, 0)},
      '{CmdAddTerm, mk(0, 0, 7, 1, 2, 3, 4, 100),             1, rs(0, 1022, 0)},
      '{CmdAddTerm, mk(0, 0, 1, 7, 0, 0, 0, 32767),           0, rs(0, 0, 0)},
      '{CmdAddTerm, mk(0, 0, 1, 7, 0, 0, 0, -32768),          0, rs(0, 0, 0)},
      '{CmdFlip,    mk(7, 0, 0, 0, 0, 0, 0, 0),               1, rs(2, 1020, 0)},
      '{CmdAddTerm, mk(0, 0, 2, 10, 11, 0, 0, -32768),        0, rs(0, 0, 0)},
      '{CmdAddTerm, mk(0, 0, 3, 10, 11, 12, 0, 32767),        0, rs(0, 0, 0)},
      '{CmdAddTerm, mk(0, 0, 4, 10, 11, 12, 13, 1234),        0, rs(0, 0, 0)},
      '{CmdAddTerm, mk(0, 0, 4, 20, 20, 20, 20, 77),          0, rs(0, 0, 0)},
      '{CmdAddTerm, mk(0, 0, 2, 1023, 1023, 0, 0, 5),         0, rs(0, 0, 0)},
      '{CmdFlip,    mk(10, 0, 0, 0, 0, 0, 0, 0),              0, rs(0, 0, 0)},
      '{CmdFlip,    mk(20, 0, 0, 0, 0, 0, 0, 0),              0, rs(0, 0, 0)},
      '{CmdFlip,    mk(1023, 0, 0, 0, 0, 0, 0, 0),            0, rs(0, 0, 0)},
      '{CmdReject,  mk(0, 0, 0, 0, 0, 0, 0, 0),               0, rs(0, 0, 0)},
      '{CmdSetSpin, mk(11, 0, 0, 0, 0, 0, 0, 0),              0, rs(0, 0, 0)},
      '{CmdFlip,    mk(12, 0, 0, 0, 0, 0, 0, 0),              0, rs(0, 0, 0)}
    };
    foreach (table_rows[i]) send_item(table_rows[i].cmd, table_rows[i].it,
                                      table_rows[i].known, table_rows[i].res);
    // fill list of site 30 past capacity, then saturate its field both ways
    for (int k = 0; k < 17; k++)
      send_item(CmdAddTerm, mk(0, 0, 2, 30, 30 + k + 1, 0, 0, 30000), 0, '0);
    for (int k = 0; k < 260; k++)
      send_item(CmdAddTerm, mk(0, 0, 1, 30, 0, 0, 0, 32767), 0, '0);
    send_item(CmdFlip, mk(30, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    for (int k = 0; k < 520; k++)
      send_item(CmdAddTerm, mk(0, 0, 1, 30, 0, 0, 0, -32768), 0, '0);
    send_item(CmdFlip, mk(30, 0, 0, 0, 0, 0, 0, 0), 0, '0);

    // long receiver hold while the sender keeps offering
    fork
      begin
        hold_rcv = 1;
        repeat (600) @(posedge clk_i);
        hold_rcv = 0;
      end
      for (int k = 0; k < 8; k++) send_item(CmdFlip, mk(10 + k, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    join
    // sender pause until everything is back
    drain();

    // random phases: mostly well-formed terms, flips and spin sets over a small hot region, plus rejects and noise
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = ph == 0 ? 27 : ph == 1 ? 55 : 0;
      rcv_idle_pct = ph == 0 ? 55 : ph == 1 ? 27 : 0;
      base = $urandom_range(NumSites - 64);
      for (int n = 0; n < 230; n++) begin
        it = rand_item();
        pick = $urandom_range(99);
        hot = $urandom_range(3) == 0 ? 0 : 1;
        if (pick < 35) begin
          cmd = CmdAddTerm;
          it.order = $urandom_range(9) == 0 ? 3'($urandom) : 3'($urandom_range(1, 4));
          if (hot) for (int q = 0; q < 4; q++) it.mem[q] = SiteW'(base + $urandom_range(63));
        end else if (pick < 75) begin
          cmd = CmdFlip;
          if (hot) it.site = SiteW'(base + $urandom_range(63));
        end else if (pick < 88) begin
          cmd = CmdSetSpin;
          if (hot) it.site = SiteW'(base + $urandom_range(63));
        end else begin
          cmd = CmdReject;
        end
        send_item(cmd, it, 0, '0);
      end
      drain();
    end

    rcv_idle_pct = 0;
    drain();
    $display("%0d items in, %0d results out, %0d flips, %0d dropped terms, %0d errors",
             accepted_in, accepted_out, flips_seen, drops_seen, errors);
    if (errors == 0 && pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/mbi_pkg.sv
rtl/multibody_ising_flip_energy_top.sv
tb/tb.sv
